[sv/rle565_pkg.sv]
// ----------------------------------------------------------------------------
// rle565_pkg
// Shared types and constants for the RLE RGB565 stream decoder: token phase
// and controller state encodings, and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package rle565_pkg;

   localparam int BYTE_W      = 8;
   localparam int PIXEL_W     = 16;
   localparam int VALID_W     = 2;
   localparam int TOTAL_W     = 20;
   localparam int MAXPIX_W    = 20;
   localparam int RUN_LEFT_W  = 8;

   localparam int               HDR_RUN_BIT  = 7;
   localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7F;
   localparam logic [MAXPIX_W-1:0] MAX_PIXELS_RESET = 20'd76800;
   localparam logic [RUN_LEFT_W-1:0] MAX_RUN_LEN = 8'd128;

   localparam logic [VALID_W-1:0] PIX_NONE = 2'd0;
   localparam logic [VALID_W-1:0] PIX_ONE  = 2'd1;
   localparam logic [VALID_W-1:0] PIX_TWO  = 2'd2;

   // token phase: what the next byte of the stream is
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LOW    = 2'd1,
      PH_HIGH   = 2'd2
   } phase_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // take the request byte this cycle
      logic run_step;  // emit the next beat of a run
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;  // output register empty or being drained
      logic run_start;  // request byte at the head completes a run token
      logic run_last;   // current run beat is the final one
   } dp_sts_type;

endpackage

[sv/rle_rgb565_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// rle_rgb565_stream_decoder_core
// PackBits-style run-length decoder for RGB565 pixel streams: one compressed
// byte per request, up to two pixels per response.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------------
//   req     | in  | req_valid / req_ready  | data_byte, end_of_data
//   rsp     | out | rsp_valid / rsp_ready  | pixel_first, pixel_second,
//           |     |                        | pixels_valid, frame_done,
//           |     |                        | pixels_total
//   csr     | in  | csr_valid / csr_ready  | max_pixels (always ready)
//
// Header, low and literal high bytes are each taken as one request. A run
// pixel byte is followed by the run's pixels (at most 128) in beats of up
// to two pixels, during which no request is taken; the controller sequences
// these beats through the single output register.
// A request is taken only while the output register is empty or drains in
// the same cycle, so a stalled response stalls the request side.
// Synchronous reset clears the frame state except the run pixel and sets max_pixels to 76800.
// ----------------------------------------------------------------------------
module rle_rgb565_stream_decoder_core
   import rle565_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = 20
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_end_of_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PIXEL_W-1:0]  rsp_pixel_first,
   output logic [PIXEL_W-1:0]  rsp_pixel_second,
   output logic [VALID_W-1:0]  rsp_pixels_valid,
   output logic                rsp_frame_done,
   output logic [TOTAL_W-1:0]  rsp_pixels_total,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [MAXPIX_W-1:0] csr_max_pixels
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // the limit register takes a write in any cycle
   assign csr_ready = 1'b1;

   rle565_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rle565_datapath #(
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_data_byte    (req_data_byte),
      .req_end_of_data  (req_end_of_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixels_valid (rsp_pixels_valid),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_pixels_total (rsp_pixels_total),
      .csr_write        (csr_valid && csr_ready),
      .csr_max_pixels   (csr_max_pixels)
   );

endmodule

[sv/rle565_ctrl.sv]
// ----------------------------------------------------------------------------
// rle565_ctrl
// Controller: takes request bytes while idle and sequences the pixel-pair
// beats of a run through the output register.
// ----------------------------------------------------------------------------
module rle565_ctrl
   import rle565_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // enter a run on an accepted run pixel byte, leave it on the final run beat
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.run_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = sts.slot_free;
            cmd.accept = req_valid && sts.slot_free;
            if (cmd.accept && sts.run_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.run_step = sts.slot_free;
            if (sts.slot_free && sts.run_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/rle565_datapath.sv]
// ----------------------------------------------------------------------------
// rle565_datapath
// Token state, pixel counter, limit register, run counter and the output
// register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module rle565_datapath
   import rle565_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = 20
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_end_of_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [PIXEL_W-1:0]   rsp_pixel_first,
   output logic [PIXEL_W-1:0]   rsp_pixel_second,
   output logic [VALID_W-1:0]   rsp_pixels_valid,
   output logic                 rsp_frame_done,
   output logic [TOTAL_W-1:0]   rsp_pixels_total,
   input  logic                 csr_write,
   input  logic [MAXPIX_W-1:0]  csr_max_pixels
);

   localparam int CW = PIXEL_COUNT_BITS;

   // frame state
   phase_type              phase_ff, phase_in;
   logic                   run_mode_ff, run_mode_in;
   logic [RUN_LEFT_W-1:0]  remain_ff, remain_in;
   logic [BYTE_W-1:0]      low_ff, low_in;
   logic [CW-1:0]          written_ff, written_in;
   logic                   stopped_ff, stopped_in;
   logic [RUN_LEFT_W-1:0]  run_left_ff, run_left_in;
   logic [PIXEL_W-1:0]     run_pix_ff, run_pix_in;
   logic                   eod_pend_ff, eod_pend_in;
   logic [MAXPIX_W-1:0]    max_pix_ff;

   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]     out_first_ff, out_first_in;
   logic [PIXEL_W-1:0]     out_second_ff, out_second_in;
   logic [VALID_W-1:0]     out_cnt_ff, out_cnt_in;
   logic                   out_done_ff, out_done_in;
   logic [TOTAL_W-1:0]     out_total_ff, out_total_in;

   // combinational helpers
   logic [CW+MAXPIX_W-1:0]  max_ext;
   logic [CW+MAXPIX_W-1:0]  mask_ext;
   logic [CW-1:0]           limit;
   logic [CW-1:0]           avail;
   logic [CW+RUN_LEFT_W-1:0] avail_ext;
   logic [CW+RUN_LEFT_W-1:0] remain_ext;
   logic [RUN_LEFT_W-1:0]   run_len;
   logic                    stop_now;
   logic                    slot_free;
   logic                    run_start;
   logic                    run_last;
   logic [PIXEL_W-1:0]      pix;
   logic [CW-1:0]           total_src;
   logic [CW+TOTAL_W-1:0]   total_ext;
   logic                    out_load;
   logic                    clear;
   logic [RUN_LEFT_W-1:0]   remain_dec;

   // clip the limit to what the pixel counter can hold
   assign max_ext  = {{CW{1'b0}}, max_pix_ff};
   assign mask_ext = {{MAXPIX_W{1'b0}}, {CW{1'b1}}};
   assign limit    = (max_ext > mask_ext) ? {CW{1'b1}} : max_ext[CW-1:0];

   // run length bounded by the pixels still allowed
   assign avail      = limit - written_ff;
   assign avail_ext  = {{RUN_LEFT_W{1'b0}}, avail};
   assign remain_ext = {{CW{1'b0}}, remain_ff};
   assign run_len    = (avail_ext < remain_ext) ? avail[RUN_LEFT_W-1:0] : remain_ff;

   assign stop_now   = stopped_ff || (written_ff >= limit);
   assign slot_free  = !out_valid_ff || rsp_ready;
   assign run_start  = !stop_now && (phase_ff == PH_HIGH) && run_mode_ff;
   assign run_last   = (run_left_ff <= RUN_LEFT_W'(2));
   assign pix        = {req_data_byte, low_ff};
   assign remain_dec = remain_ff - RUN_LEFT_W'(1);

   assign sts.slot_free = slot_free;
   assign sts.run_start = run_start;
   assign sts.run_last  = run_last;

   assign total_ext    = {{TOTAL_W{1'b0}}, total_src};
   assign out_total_in = total_ext[TOTAL_W-1:0];

   // decode a byte or a run beat
   always_comb begin
      phase_in      = phase_ff;
      run_mode_in   = run_mode_ff;
      remain_in     = remain_ff;
      low_in        = low_ff;
      written_in    = written_ff;
      stopped_in    = stopped_ff;
      run_left_in   = run_left_ff;
      run_pix_in    = run_pix_ff;
      eod_pend_in   = eod_pend_ff;
      out_load      = 1'b0;
      out_first_in  = '0;
      out_second_in = '0;
      out_cnt_in    = PIX_NONE;
      out_done_in   = 1'b0;
      total_src     = '0;
      clear         = 1'b0;

      if (cmd.accept) begin
         stopped_in = stop_now;
         if (!stop_now) begin
            case (phase_ff)
               PH_LOW: begin
                  low_in   = req_data_byte;
                  phase_in = PH_HIGH;
               end
               PH_HIGH: begin
                  if (run_mode_ff) begin
                     run_left_in = run_len;
                     run_pix_in  = pix;
                     remain_in   = '0;
                     phase_in    = PH_HEADER;
                  end else begin
                     out_load     = 1'b1;
                     out_first_in = pix;
                     out_cnt_in   = PIX_ONE;
                     written_in   = written_ff + CW'(1);
                     remain_in    = remain_dec;
                     phase_in     = (remain_dec == '0) ? PH_HEADER : PH_LOW;
                     if ((written_ff + CW'(1)) >= limit) begin
                        stopped_in = 1'b1;
                     end
                  end
               end
               default: begin
                  run_mode_in = req_data_byte[HDR_RUN_BIT];
                  remain_in   = (req_data_byte & HDR_COUNT_MASK) + RUN_LEFT_W'(1);
                  phase_in    = PH_LOW;
               end
            endcase
         end
         // frame end is reported at once, or held to the final run beat if the byte starts a run
         if (req_end_of_data) begin
            if (run_start) begin
               eod_pend_in = 1'b1;
            end else begin
               out_load    = 1'b1;
               out_done_in = 1'b1;
               total_src   = written_in;
               clear       = 1'b1;
            end
         end
      end else if (cmd.run_step) begin
         if (run_left_ff >= RUN_LEFT_W'(2)) begin
            out_load      = 1'b1;
            out_first_in  = run_pix_ff;
            out_second_in = run_pix_ff;
            out_cnt_in    = PIX_TWO;
            run_left_in   = run_left_ff - RUN_LEFT_W'(2);
            written_in    = written_ff + CW'(2);
         end else if (run_left_ff == RUN_LEFT_W'(1)) begin
            out_load     = 1'b1;
            out_first_in = run_pix_ff;
            out_cnt_in   = PIX_ONE;
            run_left_in  = '0;
            written_in   = written_ff + CW'(1);
         end
         if (run_last) begin
            if (written_in >= limit) begin
               stopped_in = 1'b1;
            end
            if (eod_pend_ff) begin
               out_load    = 1'b1;
               out_done_in = 1'b1;
               total_src   = written_in;
               clear       = 1'b1;
            end
         end
      end

      // drop all frame state after the last result
      if (clear) begin
         phase_in    = PH_HEADER;
         run_mode_in = 1'b0;
         remain_in   = '0;
         low_in      = '0;
         written_in  = '0;
         stopped_in  = 1'b0;
         run_left_in = '0;
         eod_pend_in = 1'b0;
      end

      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         run_mode_ff  <= 1'b0;
         remain_ff    <= '0;
         low_ff       <= '0;
         written_ff   <= '0;
         stopped_ff   <= 1'b0;
         run_left_ff  <= '0;
         eod_pend_ff  <= 1'b0;
         max_pix_ff   <= MAX_PIXELS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         run_mode_ff  <= run_mode_in;
         remain_ff    <= remain_in;
         low_ff       <= low_in;
         written_ff   <= written_in;
         stopped_ff   <= stopped_in;
         run_left_ff  <= run_left_in;
         eod_pend_ff  <= eod_pend_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            max_pix_ff <= csr_max_pixels;
         end
      end
   end

   // run pixel and result payload
   always_ff @(posedge clock) begin
      run_pix_ff <= run_pix_in;
      if (out_load) begin
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_cnt_ff    <= out_cnt_in;
         out_done_ff   <= out_done_in;
         out_total_ff  <= out_total_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_first  = out_first_ff;
   assign rsp_pixel_second = out_second_ff;
   assign rsp_pixels_valid = out_cnt_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_pixels_total = out_total_ff;

   // a run never holds more than one header's count
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      run_left_ff <= MAX_RUN_LEN)
      else $error("run counter above maximum run length");

   // second pixel is only carried by a pair
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_cnt_ff != PIX_TWO) |-> (out_second_ff == '0))
      else $error("second pixel set on a result without a pair");

   // total is only reported with frame end
   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_done_ff |-> (out_total_ff == '0))
      else $error("pixel total set before frame end");

   // frame end restarts the pixel count
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      out_load && out_done_in |=> (written_ff == '0) && (phase_ff == PH_HEADER))
      else $error("frame state not cleared after frame end");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rle_rgb565_stream_decoder_core. Compressed bytes
// go in from a queue through a valid/ready driver. A clocked monitor decodes
// every accepted request with its own token decoder and checks each pixel
// result against the oldest one due. Phases change max_pixels while idle and
// vary sender gaps and receiver stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import rle565_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              eod;
   } stream_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] first;
      logic [PIXEL_W-1:0] second;
      logic [VALID_W-1:0] npix;
      logic               done;
      logic [TOTAL_W-1:0] total;
   } pixel_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_end_of_data = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]  rsp_pixel_first;
   logic [PIXEL_W-1:0]  rsp_pixel_second;
   logic [VALID_W-1:0]  rsp_pixels_valid;
   logic                rsp_frame_done;
   logic [TOTAL_W-1:0]  rsp_pixels_total;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MAXPIX_W-1:0] csr_max_pixels = '0;

   // stimulus and expectations
   stream_req_type pending_bytes[$];
   pixel_beat_type pixel_beats_due[$];
   stream_req_type next_byte;
   bit          req_fire_q = 1'b0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          long_hold_asks = 0;
   int          long_hold_done = 0;
   int          hold_left = 0;
   int          err_count = 0;
   int          beat_count = 0;
   int          cycle_count = 0;

   // decoder model state
   phase_type           tok_phase;
   logic                tok_is_run;
   logic [7:0]          tok_left;
   logic [7:0]          lo_hold;
   logic [TOTAL_W-1:0]  px_written;
   logic                px_stopped;
   logic [MAXPIX_W-1:0] px_limit;

   rle_rgb565_stream_decoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_data  (req_end_of_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixels_valid (rsp_pixels_valid),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_pixels_total (rsp_pixels_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_pixels   (csr_max_pixels)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic stream_req_type stream_byte(input logic [7:0] d, input logic e);
      stream_req_type r;
      r.data = d;
      r.eod  = e;
      return r;
   endfunction

   function automatic pixel_beat_type make_beat(input logic [15:0] p1,
                                                input logic [15:0] p2,
                                                input logic [1:0] n);
      pixel_beat_type b;
      b.first  = p1;
      b.second = p2;
      b.npix   = n;
      b.done   = 1'b0;
      b.total  = '0;
      return b;
   endfunction

   function automatic void clear_frame_model();
      tok_phase  = PH_HEADER;
      tok_is_run = 1'b0;
      tok_left   = '0;
      lo_hold    = '0;
      px_written = '0;
      px_stopped = 1'b0;
   endfunction

   // decode one compressed byte and queue the pixel results it causes
   function automatic void decode_byte(input logic [7:0] b, input logic eod);
      int             n;
      int unsigned    k;
      int unsigned    avail;
      logic [15:0]    pix;
      pixel_beat_type last;
      n = 0;
      if (px_written >= px_limit) px_stopped = 1'b1;
      if (!px_stopped) begin
         case (tok_phase)
            PH_LOW: begin
               lo_hold   = b;
               tok_phase = PH_HIGH;
            end
            PH_HIGH: begin
               pix = {b, lo_hold};
               if (tok_is_run) begin
                  // clip the run at the frame limit, emit pairs then an odd tail
                  k     = 32'(tok_left);
                  avail = 32'(px_limit - px_written);
                  if (k > avail) k = avail;
                  while (k >= 2) begin
                     pixel_beats_due.push_back(make_beat(pix, pix, PIX_TWO));
                     n++;
                     k -= 2;
                     px_written = px_written + TOTAL_W'(2);
                  end
                  if (k == 1) begin
                     pixel_beats_due.push_back(make_beat(pix, '0, PIX_ONE));
                     n++;
                     px_written = px_written + TOTAL_W'(1);
                  end
                  tok_left  = '0;
                  tok_phase = PH_HEADER;
               end else begin
                  pixel_beats_due.push_back(make_beat(pix, '0, PIX_ONE));
                  n++;
                  px_written = px_written + TOTAL_W'(1);
                  tok_left  = tok_left - 8'd1;
                  tok_phase = (tok_left == 8'd0) ? PH_HEADER : PH_LOW;
               end
               if (px_written >= px_limit) px_stopped = 1'b1;
            end
            default: begin
               tok_is_run = b[HDR_RUN_BIT];
               tok_left   = (b & HDR_COUNT_MASK) + 8'd1;
               tok_phase  = PH_LOW;
            end
         endcase
      end
      // close the frame on its last byte
      if (eod) begin
         if (n == 0) pixel_beats_due.push_back(make_beat('0, '0, PIX_NONE));
         last = pixel_beats_due.pop_back();
         last.done  = 1'b1;
         last.total = px_written;
         pixel_beats_due.push_back(last);
         clear_frame_model();
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [19:0] got,
                                input logic [19:0] want);
      err_count++;
      $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
               what, beat_count, got, want);
   endtask

   // request driver: hold until accepted, then take the next byte or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire_q) begin
         req_valid <= 1'b1;
      end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         next_byte = pending_bytes.pop_front();
         req_valid       <= 1'b1;
         req_data_byte   <= next_byte.data;
         req_end_of_data <= next_byte.eod;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response side: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_asks != long_hold_done) begin
         long_hold_done++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: track config and requests, check every accepted result
   always @(posedge clock) begin : monitor
      pixel_beat_type want;
      if (reset) begin
         px_limit = MAX_PIXELS_RESET;
         clear_frame_model();
         req_fire_q = 1'b0;
      end else begin
         req_fire_q = req_valid && req_ready;
         if (csr_valid && csr_ready) px_limit = csr_max_pixels;
         if (rsp_valid && rsp_ready) begin
            if (pixel_beats_due.size() == 0) begin
               flag_mismatch("unexpected result", TOTAL_W'(rsp_pixels_valid), '0);
            end else begin
               want = pixel_beats_due.pop_front();
               if (rsp_pixel_first !== want.first)
                  flag_mismatch("pixel_first", TOTAL_W'(rsp_pixel_first),
                                TOTAL_W'(want.first));
               if (rsp_pixel_second !== want.second)
                  flag_mismatch("pixel_second", TOTAL_W'(rsp_pixel_second),
                                TOTAL_W'(want.second));
               if (rsp_pixels_valid !== want.npix)
                  flag_mismatch("pixels_valid", TOTAL_W'(rsp_pixels_valid),
                                TOTAL_W'(want.npix));
               if (rsp_frame_done !== want.done)
                  flag_mismatch("frame_done", TOTAL_W'(rsp_frame_done),
                                TOTAL_W'(want.done));
               if (rsp_pixels_total !== want.total)
                  flag_mismatch("pixels_total", rsp_pixels_total, want.total);
            end
            beat_count++;
         end
         if (req_fire_q) decode_byte(req_data_byte, req_end_of_data);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // wait until every request is taken and every result has come back
   task automatic wait_drained();
      @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || pixel_beats_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_max_pixels(input logic [MAXPIX_W-1:0] value);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_max_pixels <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // build one frame of tokens and hand it to the driver in one go
   task automatic queue_frame(output int n_bytes);
      stream_req_type frame_q[$];
      stream_req_type last;
      int          kind, cnt, np, i;
      bit          is_run;
      logic [7:0]  hdr;
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
         // noise: arbitrary bytes
         repeat ($urandom_range(1, 6)) frame_q.push_back(stream_byte(8'($urandom), 1'b0));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            is_run = 1'($urandom_range(0, 1));
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            if (!is_run && cnt > 10) cnt = 10;
            frame_q.push_back(stream_byte({is_run, 7'(cnt - 1)}, 1'b0));
            np = is_run ? 1 : cnt;
            for (i = 0; i < 2 * np; i++) frame_q.push_back(stream_byte(8'($urandom), 1'b0));
         end
         if (kind == 1) begin
            // cut the last token short
            hdr = 8'($urandom);
            frame_q.push_back(stream_byte(hdr, 1'b0));
            np = hdr[HDR_RUN_BIT] ? 0 :
                 int'($urandom_range(0, (hdr[6:0] > 7'd3) ? 3 : int'(hdr[6:0])));
            for (i = 0; i < 2 * np; i++) frame_q.push_back(stream_byte(8'($urandom), 1'b0));
            if ($urandom_range(0, 1)) frame_q.push_back(stream_byte(8'($urandom), 1'b0));
         end
      end
      last = frame_q.pop_back();
      last.eod = 1'b1;
      frame_q.push_back(last);
      n_bytes = frame_q.size();
      foreach (frame_q[j]) pending_bytes.push_back(frame_q[j]);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct,
                            input logic [MAXPIX_W-1:0] limit, input int budget,
                            input bit long_hold);
      int used, n;
      wait_drained();
      write_max_pixels(limit);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      used = 0;
      if (long_hold) begin
         // hold the response side while a long run and more frames pile up
         long_hold_asks++;
         pending_bytes.push_back(stream_byte(8'hFF, 1'b0));
         pending_bytes.push_back(stream_byte(8'($urandom), 1'b0));
         pending_bytes.push_back(stream_byte(8'($urandom), 1'b0));
         used = 3;
      end
      while (used < budget) begin
         queue_frame(n);
         used += n;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: literal pair, longest run, odd run, pixel on frame end
      pending_bytes.push_back(stream_byte(8'h01, 1'b0));
      pending_bytes.push_back(stream_byte(8'h34, 1'b0));
      pending_bytes.push_back(stream_byte(8'h12, 1'b0));
      pending_bytes.push_back(stream_byte(8'hFF, 1'b0));
      pending_bytes.push_back(stream_byte(8'hFF, 1'b0));
      pending_bytes.push_back(stream_byte(8'hFF, 1'b0));
      pending_bytes.push_back(stream_byte(8'h00, 1'b0));
      pending_bytes.push_back(stream_byte(8'h00, 1'b0));
      pending_bytes.push_back(stream_byte(8'h82, 1'b0));
      pending_bytes.push_back(stream_byte(8'h11, 1'b0));
      pending_bytes.push_back(stream_byte(8'h22, 1'b0));
      pending_bytes.push_back(stream_byte(8'h00, 1'b0));
      pending_bytes.push_back(stream_byte(8'hAA, 1'b0));
      pending_bytes.push_back(stream_byte(8'h55, 1'b1));
      // truncated run after its low byte, then a lone header as frame end
      pending_bytes.push_back(stream_byte(8'h81, 1'b0));
      pending_bytes.push_back(stream_byte(8'h10, 1'b1));
      pending_bytes.push_back(stream_byte(8'h7F, 1'b1));

      // zero limit: everything ignored
      wait_drained();
      write_max_pixels('0);
      pending_bytes.push_back(stream_byte(8'h83, 1'b0));
      pending_bytes.push_back(stream_byte(8'h01, 1'b0));
      pending_bytes.push_back(stream_byte(8'h02, 1'b1));

      // run clipped at the limit, rest of the frame dropped
      wait_drained();
      write_max_pixels(20'd5);
      pending_bytes.push_back(stream_byte(8'h87, 1'b0));
      pending_bytes.push_back(stream_byte(8'h0F, 1'b0));
      pending_bytes.push_back(stream_byte(8'hF0, 1'b0));
      pending_bytes.push_back(stream_byte(8'h00, 1'b1));

      // limit lowered in the middle of a frame
      wait_drained();
      write_max_pixels(20'hFFFFF);
      pending_bytes.push_back(stream_byte(8'h01, 1'b0));
      pending_bytes.push_back(stream_byte(8'h11, 1'b0));
      pending_bytes.push_back(stream_byte(8'h22, 1'b0));
      wait_drained();
      write_max_pixels(20'd1);
      pending_bytes.push_back(stream_byte(8'h33, 1'b0));
      pending_bytes.push_back(stream_byte(8'h44, 1'b1));

      // random phases
      run_phase(0, 0, 20'hFFFFF, 16, 1'b0);
      run_phase(74, 0, 20'($urandom_range(16, 160)), 16, 1'b0);
      run_phase(0, 74, MAX_PIXELS_RESET, 16, 1'b0);
      run_phase(17, 17, 20'($urandom_range(1, 60)), 16, 1'b0);
      run_phase(0, 0, 20'hFFFFF, 16, 1'b1);

      wait_drained();
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
sv/rle565_pkg.sv
sv/rle565_ctrl.sv
sv/rle565_datapath.sv
sv/rle_rgb565_stream_decoder_core.sv
tb/tb_top.sv
